[sv/frr_pkg.sv]
package frr_pkg;

  // Frame layout and protocol constants.
  localparam int          HEADER_BYTES = 9;
  localparam logic [7:0]  MAGIC_A      = 8'h56;
  localparam logic [7:0]  MAGIC_B      = 8'h55;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_MSB      = 16'h8000;

  // Result status codes.
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_INCOMPLETE = 3'd1;
  localparam logic [2:0] STAT_INVALID    = 3'd2;
  localparam logic [2:0] STAT_BAD_LEN    = 3'd3;
  localparam logic [2:0] STAT_BAD_CRC    = 3'd4;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_JUDGE,
    S_CRC_RD,
    S_CRC_LD,
    S_CRC_BIT,
    S_CHECK,
    S_EMIT_RD,
    S_EMIT_PUT,
    S_PUT_ONE
  } fsm_t;

  // Commands to the CRC unit.
  typedef struct packed {
    logic init;
    logic load;
    logic step;
  } crc_ctl_t;

  // Header check result: chunk size and chunk base address in the store.
  typedef struct packed {
    logic       ok;
    logic [6:0] chunk;
    logic [8:0] base;
  } hdr_res_t;

endpackage

[sv/frr_if.sv]
interface frr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface frr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] completed_id;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output status, output completed_id, output payload_byte,
                  output byte_valid, output last, input ready);
  modport sink   (input valid, input status, input completed_id, input payload_byte,
                  input byte_valid, input last, output ready);
endinterface

[sv/frr_hdr_chk.sv]
module frr_hdr_chk #(
  parameter int CHUNK_BYTES   = 8,
  parameter int PAYLOAD_MAX   = 48,
  parameter int FRAGMENTS_MAX = 8
) (
  input  logic [7:0]       hdr [frr_pkg::HEADER_BYTES],
  input  logic [7:0]       version,
  output frr_pkg::hdr_res_t res
);
  import frr_pkg::*;

  logic [7:0]  idx, cnt, tot;
  logic [15:0] cnt_hi, cnt_lo, base, rem, chunk;
  logic        magic_ok, tot_ok, cnt_ok;

  // The count must equal the number of chunks that the total length needs.
  always_comb begin
    idx      = hdr[4];
    cnt      = hdr[5];
    tot      = hdr[6];
    cnt_hi   = 16'(cnt) * 16'(CHUNK_BYTES);
    cnt_lo   = cnt_hi - 16'(CHUNK_BYTES);
    base     = 16'(idx) * 16'(CHUNK_BYTES);
    rem      = 16'(tot) - base;
    chunk    = (rem < 16'(CHUNK_BYTES)) ? rem : 16'(CHUNK_BYTES);
    magic_ok = (hdr[0] == MAGIC_A) && (hdr[1] == MAGIC_B) && (hdr[2] == version);
    tot_ok   = (tot != 8'd0) && (16'(tot) <= 16'(PAYLOAD_MAX));
    cnt_ok   = (cnt != 8'd0) && (cnt_lo < 16'(tot)) && (cnt_hi >= 16'(tot)) &&
               (16'(cnt) <= 16'(FRAGMENTS_MAX)) && (idx < cnt);
    res.ok    = magic_ok && tot_ok && cnt_ok;
    res.chunk = res.ok ? chunk[6:0] : 7'd0;
    res.base  = base[8:0];
  end

endmodule

[sv/frr_crc.sv]
module frr_crc (
  input  logic              clk,
  input  logic              rst_n,
  input  frr_pkg::crc_ctl_t ctl,
  input  logic [7:0]        data,
  output logic [15:0]       crc
);
  import frr_pkg::*;

  logic [15:0] crc_r, crc_nxt;

  // One byte merge or one bit of the CRC-16/CCITT-FALSE division per cycle.
  always_comb begin
    crc_nxt = crc_r;
    if (ctl.init) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.load) begin
      crc_nxt = crc_r ^ {data, 8'h00};
    end else if (ctl.step) begin
      if ((crc_r & CRC_MSB) != 16'h0000) begin
        crc_nxt = {crc_r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc_nxt = {crc_r[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

[sv/fragment_frame_reassembler.sv]
// Fragment reassembler: frame bytes enter one per item, the last byte of a frame
// flagged by frame_end. A byte without frame_end gives no result. A frame end
// moves the block to a judging state; a frame that is judged invalid, short,
// mismatched or incomplete then gives one status item once the output register
// is free. When the last fragment of a message arrives, a single bit-serial CRC
// unit walks the stored payload byte by byte (one read, one merge, one shift per
// bit). On a CRC match each payload byte is read from the store and handed out,
// else a bad-CRC status item goes out; the input is held until the result is out.
// Results leave through an output register; a result waiting there delays the
// block only when the next result is due. The version register sits at address 0.
module fragment_frame_reassembler #(
  parameter int CHUNK_BYTES     = 8,
  parameter int PAYLOAD_MAX     = 48,
  parameter int FRAGMENTS_MAX   = 8,
  parameter int FRAME_MAX_BYTES = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  frr_in_if.sink            in_ch,
  frr_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import frr_pkg::*;

  localparam int IW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int CW = $clog2(PAYLOAD_MAX + 1);

  fsm_t        state_r, state_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  hdr_r [HEADER_BYTES];
  logic [7:0]  hdr_nxt [HEADER_BYTES];
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  sess_mask_r, sess_mask_nxt;
  logic [7:0]  sess_id_r, sess_id_nxt;
  logic [7:0]  sess_cnt_r, sess_cnt_nxt;
  logic [7:0]  sess_tot_r, sess_tot_nxt;
  logic [15:0] sess_crc_r, sess_crc_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  o_stat_r, o_stat_nxt;
  logic [7:0]  o_id_r, o_id_nxt;
  logic [7:0]  o_byte_r, o_byte_nxt;
  logic        o_bv_r, o_bv_nxt;
  logic        o_last_r, o_last_nxt;

  logic [7:0]  mem [PAYLOAD_MAX];
  logic [7:0]  rd_data_r;

  hdr_res_t    hres;
  crc_ctl_t    crc_ctl;
  logic [15:0] crc_val;

  logic        accept, wr_en, slot_free, last_byte, done;
  logic [7:0]  k;
  logic [9:0]  at;
  logic [15:0] frame_crc;
  logic        len_bad, len_mis, new_sess, mism;
  logic [7:0]  mask_new;
  logic [8:0]  full9;
  logic [2:0]  judge_stat;

  frr_hdr_chk #(
    .CHUNK_BYTES   (CHUNK_BYTES),
    .PAYLOAD_MAX   (PAYLOAD_MAX),
    .FRAGMENTS_MAX (FRAGMENTS_MAX)
  ) u_hdr_chk (
    .hdr     (hdr_r),
    .version (ver_r),
    .res     (hres)
  );

  frr_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .data  (rd_data_r),
    .crc   (crc_val)
  );

  // Handshakes and configuration read-back.
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign slot_free    = !ov_r || out_ch.ready;
  assign out_ch.valid        = ov_r;
  assign out_ch.status       = o_stat_r;
  assign out_ch.completed_id = o_id_r;
  assign out_ch.payload_byte = o_byte_r;
  assign out_ch.byte_valid   = o_bv_r;
  assign out_ch.last         = o_last_r;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, ver_r};

  // Chunk bytes go to the store while they arrive.
  always_comb begin
    k     = pos_r - 8'(HEADER_BYTES);
    at    = 10'(hres.base) + 10'(k);
    wr_en = accept && (pos_r >= 8'(HEADER_BYTES)) && hres.ok &&
            (k < 8'(hres.chunk)) && (at < 10'(PAYLOAD_MAX));
  end

  // Judging a completed frame against the header and the open session.
  always_comb begin
    frame_crc = {hdr_r[8], hdr_r[7]};
    len_bad   = (pos_r < 8'(HEADER_BYTES)) || (pos_r > 8'(FRAME_MAX_BYTES));
    len_mis   = pos_r != (8'(HEADER_BYTES) + 8'(hres.chunk));
    new_sess  = (sess_mask_r == 8'd0) || (sess_id_r != hdr_r[3]);
    mism      = !new_sess && ((sess_cnt_r != hdr_r[5]) || (sess_tot_r != hdr_r[6]) ||
                              (sess_crc_r != frame_crc));
    mask_new  = (new_sess ? 8'd0 : sess_mask_r) | (8'd1 << hdr_r[4][2:0]);
    full9     = (9'd1 << hdr_r[5][3:0]) - 9'd1;
    if (len_bad || !hres.ok) begin
      judge_stat = STAT_INVALID;
    end else if (len_mis) begin
      judge_stat = STAT_BAD_LEN;
    end else if (mism) begin
      judge_stat = STAT_INVALID;
    end else if (mask_new != full9[7:0]) begin
      judge_stat = STAT_INCOMPLETE;
    end else begin
      judge_stat = STAT_OK;
    end
    last_byte = (9'(idx_r) + 9'd1) == 9'(sess_tot_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (accept && in_ch.frame_end) state_nxt = S_JUDGE;
      S_JUDGE:    state_nxt = (judge_stat == STAT_OK) ? S_CRC_RD : S_PUT_ONE;
      S_CRC_RD:   state_nxt = S_CRC_LD;
      S_CRC_LD:   state_nxt = S_CRC_BIT;
      S_CRC_BIT: begin
        if (bit_r == 3'd7) state_nxt = last_byte ? S_CHECK : S_CRC_RD;
      end
      S_CHECK:    state_nxt = (crc_val == sess_crc_r) ? S_EMIT_RD : S_PUT_ONE;
      S_EMIT_RD:  state_nxt = S_EMIT_PUT;
      S_EMIT_PUT: begin
        if (slot_free) state_nxt = last_byte ? S_IDLE : S_EMIT_RD;
      end
      S_PUT_ONE:  if (slot_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    pos_nxt       = pos_r;
    hdr_nxt       = hdr_r;
    ver_nxt       = ver_r;
    sess_mask_nxt = sess_mask_r;
    sess_id_nxt   = sess_id_r;
    sess_cnt_nxt  = sess_cnt_r;
    sess_tot_nxt  = sess_tot_r;
    sess_crc_nxt  = sess_crc_r;
    stat_nxt      = stat_r;
    idx_nxt       = idx_r;
    bit_nxt       = bit_r;
    ov_nxt        = ov_r && !out_ch.ready;
    o_stat_nxt    = o_stat_r;
    o_id_nxt      = o_id_r;
    o_byte_nxt    = o_byte_r;
    o_bv_nxt      = o_bv_r;
    o_last_nxt    = o_last_r;
    crc_ctl       = '0;
    done          = 1'b0;

    if (psel && penable && pwrite && pready && !paddr[2]) begin
      ver_nxt = pwdata[7:0];
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (pos_r < 8'(HEADER_BYTES)) hdr_nxt[pos_r[3:0]] = in_ch.frame_byte;
          if (pos_r != 8'hFF) pos_nxt = pos_r + 8'd1;
        end
      end
      S_JUDGE: begin
        stat_nxt = judge_stat;
        idx_nxt  = '0;
        bit_nxt  = 3'd0;
        crc_ctl.init = 1'b1;
        if ((judge_stat == STAT_INVALID) || (judge_stat == STAT_BAD_LEN)) begin
          sess_mask_nxt = 8'd0;
          sess_id_nxt   = 8'd0;
          sess_cnt_nxt  = 8'd0;
          sess_tot_nxt  = 8'd0;
          sess_crc_nxt  = 16'd0;
        end else begin
          if (new_sess) begin
            sess_id_nxt  = hdr_r[3];
            sess_cnt_nxt = hdr_r[5];
            sess_tot_nxt = hdr_r[6];
            sess_crc_nxt = frame_crc;
          end
          sess_mask_nxt = mask_new;
        end
      end
      S_CRC_LD: begin
        crc_ctl.load = 1'b1;
      end
      S_CRC_BIT: begin
        crc_ctl.step = 1'b1;
        bit_nxt      = bit_r + 3'd1;
        if (bit_r == 3'd7) idx_nxt = last_byte ? '0 : idx_r + CW'(1);
      end
      S_CHECK: begin
        // On a CRC match the total length stays until the payload has been streamed out.
        stat_nxt      = (crc_val == sess_crc_r) ? STAT_OK : STAT_BAD_CRC;
        sess_mask_nxt = 8'd0;
        sess_id_nxt   = 8'd0;
        sess_cnt_nxt  = 8'd0;
        if (crc_val != sess_crc_r) sess_tot_nxt = 8'd0;
        sess_crc_nxt  = 16'd0;
      end
      S_EMIT_PUT: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          o_stat_nxt = STAT_OK;
          o_id_nxt   = hdr_r[3];
          o_byte_nxt = rd_data_r;
          o_bv_nxt   = 1'b1;
          o_last_nxt = last_byte;
          idx_nxt    = idx_r + CW'(1);
          done       = last_byte;
          if (last_byte) sess_tot_nxt = 8'd0;
        end
      end
      S_PUT_ONE: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          o_stat_nxt = stat_r;
          o_id_nxt   = hdr_r[3];
          o_byte_nxt = 8'd0;
          o_bv_nxt   = 1'b0;
          o_last_nxt = 1'b1;
          done       = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // A judged frame leaves a clean header for the next one.
    if (done) begin
      pos_nxt = 8'd0;
      for (int i = 0; i < HEADER_BYTES; i++) hdr_nxt[i] = 8'd0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= 8'd0;
      ver_r       <= 8'd1;
      sess_mask_r <= 8'd0;
      sess_id_r   <= 8'd0;
      sess_cnt_r  <= 8'd0;
      sess_tot_r  <= 8'd0;
      sess_crc_r  <= 16'd0;
      ov_r        <= 1'b0;
      for (int i = 0; i < HEADER_BYTES; i++) hdr_r[i] <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      ver_r       <= ver_nxt;
      sess_mask_r <= sess_mask_nxt;
      sess_id_r   <= sess_id_nxt;
      sess_cnt_r  <= sess_cnt_nxt;
      sess_tot_r  <= sess_tot_nxt;
      sess_crc_r  <= sess_crc_nxt;
      ov_r        <= ov_nxt;
      hdr_r       <= hdr_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    stat_r   <= stat_nxt;
    idx_r    <= idx_nxt;
    bit_r    <= bit_nxt;
    o_stat_r <= o_stat_nxt;
    o_id_r   <= o_id_nxt;
    o_byte_r <= o_byte_nxt;
    o_bv_r   <= o_bv_nxt;
    o_last_r <= o_last_nxt;
  end

  // Payload store with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[at[IW-1:0]] <= in_ch.frame_byte;
    rd_data_r <= mem[idx_r[IW-1:0]];
  end

`ifndef ASSERT_OFF
  a_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.frame_end |=> !in_ch.ready)
    else $error("input taken during judging");
  a_status_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !o_bv_r |-> o_last_r)
    else $error("status item without last");
  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && o_bv_r |-> o_stat_r == STAT_OK)
    else $error("payload byte with error status");
  a_check_has_session: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> sess_mask_r != 8'd0)
    else $error("crc check without open session");
`endif

endmodule
